### hdl/rsnp_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rsnp_pkg: shared types and constants for the ray/sphere nearest picker
// Item and result structs, controller states, datapath commands and the
// widths of the fixed-point datapath.
// ---------------------------------------------------------------------------
package rsnp_pkg;

  // Sphere limit per ray and derived counter widths
  localparam int MAX_SPHERES = 256;
  localparam int CNT_W       = $clog2(MAX_SPHERES + 1);
  localparam int INDEX_W     = 8;

  // Datapath widths
  localparam int COORD_W = 32;            // Q16.16 coordinates
  localparam int DIFF_W  = COORD_W + 1;   // end - start, and its magnitude
  localparam int DIR_W   = 32;            // Q1.30 direction
  localparam int OC8_W   = DIFF_W - 8;    // origin - centre in Q.8
  localparam int MUL_W   = 33;            // signed multiplier operand
  localparam int ACC_W   = 64;            // sum of squares / discriminant
  localparam int B_W     = 33;            // b in Q.8
  localparam int T_W     = 35;            // hit time in Q.8
  localparam int ROOT_W  = 32;            // integer square root
  localparam int QUO_W   = 31;            // direction quotient
  localparam int DIV_STEPS = QUO_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);
  localparam int ROOT_STEPS = ACC_W / 2;
  localparam int ROOT_CNT_W = $clog2(ROOT_STEPS);
  localparam int NORM_SHIFT = 30;         // direction fraction bits
  localparam logic [30:0] TIME_MAX = 31'h7FFF_FFFF;

  // Operation codes
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SPHERE = 1'b1;

  typedef struct packed {
    logic                       op;
    logic signed [COORD_W-1:0]  ray_start_x;
    logic signed [COORD_W-1:0]  ray_start_y;
    logic signed [COORD_W-1:0]  ray_start_z;
    logic signed [COORD_W-1:0]  ray_end_x;
    logic signed [COORD_W-1:0]  ray_end_y;
    logic signed [COORD_W-1:0]  ray_end_z;
    logic signed [15:0]         center_x;
    logic signed [15:0]         center_y;
    logic signed [15:0]         center_z;
    logic [15:0]                radius;
    logic                       last;
  } in_t;

  typedef struct packed {
    logic               hit;
    logic [INDEX_W-1:0] nearest_index;
    logic [30:0]        nearest_time;
  } out_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_LD_DIFF,
    ST_LD_NORM,
    ST_LD_SQ,
    ST_LD_ACC,
    ST_LD_ROOT_GO,
    ST_LD_ROOT,
    ST_LD_DIV_INIT,
    ST_LD_DIV,
    ST_LD_DIV_STORE,
    ST_SP_CHECK,
    ST_SP_B,
    ST_SP_BEND,
    ST_SP_C,
    ST_SP_R,
    ST_SP_CEND,
    ST_SP_BB,
    ST_SP_DISC,
    ST_SP_ROOT_GO,
    ST_SP_ROOT,
    ST_SP_TIME,
    ST_SP_UPD,
    ST_EMIT
  } state_e;

  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_CAPTURE,
    CMD_LD_DIFF,
    CMD_LD_ZERO,
    CMD_LD_SHR,
    CMD_LD_SHL,
    CMD_SQ,
    CMD_ACC,
    CMD_ROOT_GO,
    CMD_DIV_INIT,
    CMD_DIV_STEP,
    CMD_DIV_STORE,
    CMD_SP_OC,
    CMD_SP_B,
    CMD_SP_BEND,
    CMD_SP_C,
    CMD_SP_R,
    CMD_SP_CEND,
    CMD_SP_BB,
    CMD_SP_DISC,
    CMD_SP_TIME,
    CMD_SP_UPD,
    CMD_EMIT
  } cmd_e;

  typedef struct packed {
    cmd_e       cmd;
    logic [1:0] lane;
  } ctrl_t;

  typedef struct packed {
    logic op;
    logic last;
    logic m_zero;
    logic m_big;
    logic m_small;
    logic root_busy;
    logic div_last;
    logic cnt_full;
    logic dir_zero;
    logic disc_neg;
  } stat_t;

endpackage

### hdl/ray_sphere_nearest_pick.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ray_sphere_nearest_pick: nearest ray/sphere hit picker
//
//   channel | ports               | transfer
//   --------+---------------------+-----------------------------------
//   item    | start, in_i         | start high while busy is low
//   result  | valid_o, res_o      | valid_o high for one cycle
//
// A ray load keeps busy through dispatch, the difference, up to 29 normalization
// shifts, three squares, their sum, the square root and three divides; it ends
// early on a zero-length ray. A sphere test runs the 32-step iterative square
// root and ends early on a negative discriminant, an empty ray or a full
// counter; when it emits, an emit step follows.
// The result shows in the cycle after the last step; busy falls in that cycle.
// Reset clears the ray to zero and the best hit. Results cannot be stalled.
// ---------------------------------------------------------------------------
module ray_sphere_nearest_pick (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  rsnp_pkg::in_t  in_i,
  output logic           valid_o,
  output rsnp_pkg::out_t res_o
);
  import rsnp_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  rsnp_ctrl u_ctrl (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .stat_i(stat),
    .ctrl_o(ctrl)
  );

  rsnp_dp u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .ctrl_i (ctrl),
    .stat_o (stat),
    .valid_o(valid_o),
    .res_o  (res_o)
  );

endmodule

### hdl/rsnp_isqrt.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rsnp_isqrt: iterative integer square root
// Bit-pair restoring root of a 64-bit value, one result bit per cycle.
// ---------------------------------------------------------------------------
module rsnp_isqrt (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [rsnp_pkg::ACC_W-1:0] x_i,
  output logic                       busy_o,
  output logic [rsnp_pkg::ROOT_W-1:0] root_o
);
  import rsnp_pkg::*;

  logic [ACC_W-1:0]      x_q, x_d;
  logic [ACC_W-1:0]      res_q, res_d;
  logic [ACC_W-1:0]      bit_q, bit_d;
  logic [ROOT_CNT_W-1:0] cnt_q, cnt_d;
  logic                  run_q, run_d;
  logic [ACC_W-1:0]      trial;

  // One iteration per cycle
  always_comb begin
    trial = res_q + bit_q;
    x_d   = x_q;
    res_d = res_q;
    bit_d = bit_q;
    cnt_d = cnt_q;
    run_d = run_q;
    if (start_i) begin
      x_d   = x_i;
      res_d = '0;
      bit_d = {2'b01, {(ACC_W-2){1'b0}}};
      cnt_d = '0;
      run_d = 1'b1;
    end else if (run_q) begin
      if (x_q >= trial) begin
        x_d   = x_q - trial;
        res_d = (res_q >> 1) + bit_q;
      end else begin
        res_d = res_q >> 1;
      end
      bit_d = bit_q >> 2;
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == ROOT_CNT_W'(ROOT_STEPS - 1)) begin
        run_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      run_q <= run_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    res_q <= res_d;
    bit_q <= bit_d;
  end

  assign busy_o = run_q;
  assign root_o = res_q[ROOT_W-1:0];

endmodule

### hdl/rsnp_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rsnp_ctrl: sequencing state machine
// Steps the datapath through ray load and sphere test sequences.
// ---------------------------------------------------------------------------
module rsnp_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  rsnp_pkg::stat_t stat_i,
  output rsnp_pkg::ctrl_t ctrl_o
);
  import rsnp_pkg::*;

  state_e     state_q, state_d;
  logic [1:0] lane_q, lane_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      lane_q  <= '0;
    end else begin
      state_q <= state_d;
      lane_q  <= lane_d;
    end
  end

  // Next state and command
  always_comb begin
    state_d     = state_q;
    lane_d      = lane_q;
    ctrl_o.cmd  = CMD_NONE;
    ctrl_o.lane = lane_q;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          ctrl_o.cmd = CMD_CAPTURE;
          state_d    = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        state_d = (stat_i.op == OP_LOAD) ? ST_LD_DIFF : ST_SP_CHECK;
      end
      // Ray load
      ST_LD_DIFF: begin
        ctrl_o.cmd = CMD_LD_DIFF;
        state_d    = ST_LD_NORM;
      end
      ST_LD_NORM: begin
        if (stat_i.m_zero) begin
          ctrl_o.cmd = CMD_LD_ZERO;
          state_d    = ST_IDLE;
        end else if (stat_i.m_big) begin
          ctrl_o.cmd = CMD_LD_SHR;
        end else if (stat_i.m_small) begin
          ctrl_o.cmd = CMD_LD_SHL;
        end else begin
          lane_d  = '0;
          state_d = ST_LD_SQ;
        end
      end
      ST_LD_SQ: begin
        ctrl_o.cmd = CMD_SQ;
        if (lane_q == 2'd2) begin
          state_d = ST_LD_ACC;
        end else begin
          lane_d = lane_q + 1'b1;
        end
      end
      ST_LD_ACC: begin
        ctrl_o.cmd = CMD_ACC;
        state_d    = ST_LD_ROOT_GO;
      end
      ST_LD_ROOT_GO: begin
        ctrl_o.cmd = CMD_ROOT_GO;
        state_d    = ST_LD_ROOT;
      end
      ST_LD_ROOT: begin
        if (!stat_i.root_busy) begin
          lane_d  = '0;
          state_d = ST_LD_DIV_INIT;
        end
      end
      ST_LD_DIV_INIT: begin
        ctrl_o.cmd = CMD_DIV_INIT;
        state_d    = ST_LD_DIV;
      end
      ST_LD_DIV: begin
        ctrl_o.cmd = CMD_DIV_STEP;
        if (stat_i.div_last) begin
          state_d = ST_LD_DIV_STORE;
        end
      end
      ST_LD_DIV_STORE: begin
        ctrl_o.cmd = CMD_DIV_STORE;
        if (lane_q == 2'd2) begin
          state_d = ST_IDLE;
        end else begin
          lane_d  = lane_q + 1'b1;
          state_d = ST_LD_DIV_INIT;
        end
      end
      // Sphere test
      ST_SP_CHECK: begin
        if (stat_i.cnt_full) begin
          state_d = stat_i.last ? ST_EMIT : ST_IDLE;
        end else begin
          ctrl_o.cmd = CMD_SP_OC;
          lane_d     = '0;
          if (stat_i.dir_zero) begin
            state_d = stat_i.last ? ST_EMIT : ST_IDLE;
          end else begin
            state_d = ST_SP_B;
          end
        end
      end
      ST_SP_B: begin
        ctrl_o.cmd = CMD_SP_B;
        if (lane_q == 2'd2) begin
          state_d = ST_SP_BEND;
        end else begin
          lane_d = lane_q + 1'b1;
        end
      end
      ST_SP_BEND: begin
        ctrl_o.cmd = CMD_SP_BEND;
        lane_d     = '0;
        state_d    = ST_SP_C;
      end
      ST_SP_C: begin
        ctrl_o.cmd = CMD_SP_C;
        if (lane_q == 2'd2) begin
          state_d = ST_SP_R;
        end else begin
          lane_d = lane_q + 1'b1;
        end
      end
      ST_SP_R: begin
        ctrl_o.cmd = CMD_SP_R;
        state_d    = ST_SP_CEND;
      end
      ST_SP_CEND: begin
        ctrl_o.cmd = CMD_SP_CEND;
        state_d    = ST_SP_BB;
      end
      ST_SP_BB: begin
        ctrl_o.cmd = CMD_SP_BB;
        state_d    = ST_SP_DISC;
      end
      ST_SP_DISC: begin
        ctrl_o.cmd = CMD_SP_DISC;
        state_d    = ST_SP_ROOT_GO;
      end
      ST_SP_ROOT_GO: begin
        if (stat_i.disc_neg) begin
          state_d = stat_i.last ? ST_EMIT : ST_IDLE;
        end else begin
          ctrl_o.cmd = CMD_ROOT_GO;
          state_d    = ST_SP_ROOT;
        end
      end
      ST_SP_ROOT: begin
        if (!stat_i.root_busy) begin
          state_d = ST_SP_TIME;
        end
      end
      ST_SP_TIME: begin
        ctrl_o.cmd = CMD_SP_TIME;
        state_d    = ST_SP_UPD;
      end
      ST_SP_UPD: begin
        ctrl_o.cmd = CMD_SP_UPD;
        state_d    = stat_i.last ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        ctrl_o.cmd = CMD_EMIT;
        state_d    = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy = (state_q != ST_IDLE);

endmodule

### hdl/rsnp_dp.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rsnp_dp: fixed-point datapath
// Ray state, one shared multiplier, bit-serial divider, root unit and the
// best-hit tracker with its result register.
// ---------------------------------------------------------------------------
module rsnp_dp (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  rsnp_pkg::in_t   in_i,
  input  rsnp_pkg::ctrl_t ctrl_i,
  output rsnp_pkg::stat_t stat_o,
  output logic            valid_o,
  output rsnp_pkg::out_t  res_o
);
  import rsnp_pkg::*;

  in_t                       in_q;
  logic signed [COORD_W-1:0] origin_q [3];
  logic signed [DIR_W-1:0]   dir_q    [3];
  logic [DIFF_W-1:0]         mag_q    [3];
  logic                      neg_q    [3];
  logic signed [OC8_W-1:0]   oc8_q    [3];
  logic signed [ACC_W-1:0]   p_q;
  logic signed [ACC_W-1:0]   acc_q;
  logic signed [B_W-1:0]     b_q;
  logic signed [T_W-1:0]     t_q;
  logic [DIFF_W-1:0]         rem_q;
  logic [QUO_W-1:0]          dvd_q;
  logic [QUO_W-1:0]          quo_q;
  logic [DIV_CNT_W-1:0]      dcnt_q;
  logic [CNT_W-1:0]          count_q;
  logic [INDEX_W-1:0]        idx_q;
  logic [31:0]               best_time_q;
  logic [INDEX_W-1:0]        best_index_q;
  logic                      best_valid_q;
  logic                      valid_q;
  out_t                      res_q;

  logic signed [COORD_W-1:0] s_vec [3];
  logic signed [COORD_W-1:0] e_vec [3];
  logic signed [15:0]        c_vec [3];
  logic [DIFF_W-1:0]         m_max;
  logic signed [MUL_W-1:0]   mul_a, mul_b;
  logic signed [2*MUL_W-1:0] prod;
  logic signed [ACC_W-1:0]   p_shr;
  logic [DIFF_W-1:0]         div_try;
  logic                      div_ge;
  logic                      root_go;
  logic                      root_busy;
  logic [ROOT_W-1:0]         root;
  logic [31:0]               t16;
  logic [1:0]                ln;

  assign ln = ctrl_i.lane;
  assign s_vec[0] = in_q.ray_start_x;
  assign s_vec[1] = in_q.ray_start_y;
  assign s_vec[2] = in_q.ray_start_z;
  assign e_vec[0] = in_q.ray_end_x;
  assign e_vec[1] = in_q.ray_end_y;
  assign e_vec[2] = in_q.ray_end_z;
  assign c_vec[0] = in_q.center_x;
  assign c_vec[1] = in_q.center_y;
  assign c_vec[2] = in_q.center_z;

  // Largest component magnitude
  always_comb begin
    m_max = mag_q[0];
    if (mag_q[1] > m_max) m_max = mag_q[1];
    if (mag_q[2] > m_max) m_max = mag_q[2];
  end

  // Shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (ctrl_i.cmd)
      CMD_SQ: begin
        mul_a = MUL_W'($signed({1'b0, mag_q[ln]}));
        mul_b = mul_a;
      end
      CMD_SP_B: begin
        mul_a = MUL_W'(oc8_q[ln]);
        mul_b = MUL_W'(dir_q[ln]);
      end
      CMD_SP_C: begin
        mul_a = MUL_W'(oc8_q[ln]);
        mul_b = mul_a;
      end
      CMD_SP_R: begin
        mul_a = MUL_W'($signed({1'b0, in_q.radius}));
        mul_b = mul_a;
      end
      CMD_SP_BB: begin
        mul_a = MUL_W'(b_q);
        mul_b = mul_a;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod  = mul_a * mul_b;
  assign p_shr = p_q >>> NORM_SHIFT;

  // Divider step: restoring, one quotient bit per cycle
  assign div_try = {rem_q[DIFF_W-2:0], dvd_q[QUO_W-1]};
  assign div_ge  = (div_try >= DIFF_W'(root));

  // Saturated time in Q16.16
  assign t16 = (|t_q[T_W-2:23]) ? {1'b0, TIME_MAX} : {1'b0, t_q[22:0], 8'b0};

  assign root_go = (ctrl_i.cmd == CMD_ROOT_GO);

  rsnp_isqrt u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(root_go),
    .x_i    (acc_q),
    .busy_o (root_busy),
    .root_o (root)
  );

  // Payload registers
  always_ff @(posedge clk_i) begin
    case (ctrl_i.cmd)
      CMD_CAPTURE: begin
        in_q <= in_i;
      end
      CMD_LD_DIFF: begin
        for (int i = 0; i < 3; i++) begin
          logic signed [DIFF_W-1:0] d;
          d = DIFF_W'(e_vec[i]) - DIFF_W'(s_vec[i]);
          neg_q[i] <= d[DIFF_W-1];
          mag_q[i] <= d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
        end
      end
      CMD_LD_SHR: begin
        for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] >> 1;
      end
      CMD_LD_SHL: begin
        for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] << 1;
      end
      CMD_SQ: begin
        p_q   <= prod[ACC_W-1:0];
        acc_q <= (ln == 2'd0) ? '0 : acc_q + p_q;
      end
      CMD_ACC: begin
        acc_q <= acc_q + p_q;
      end
      CMD_DIV_INIT: begin
        rem_q  <= {1'b0, mag_q[ln][DIFF_W-1:1]};
        dvd_q  <= {mag_q[ln][0], {(QUO_W-1){1'b0}}};
        quo_q  <= '0;
        dcnt_q <= '0;
      end
      CMD_DIV_STEP: begin
        rem_q  <= div_ge ? div_try - DIFF_W'(root) : div_try;
        quo_q  <= {quo_q[QUO_W-2:0], div_ge};
        dvd_q  <= dvd_q << 1;
        dcnt_q <= dcnt_q + 1'b1;
      end
      CMD_SP_OC: begin
        for (int i = 0; i < 3; i++) begin
          logic signed [DIFF_W-1:0] oc;
          oc = DIFF_W'(origin_q[i]) - DIFF_W'($signed({c_vec[i], 16'b0}));
          oc8_q[i] <= oc[DIFF_W-1:8];
        end
        idx_q <= count_q[INDEX_W-1:0];
      end
      CMD_SP_B: begin
        p_q <= prod[ACC_W-1:0];
        b_q <= (ln == 2'd0) ? '0 : b_q + p_shr[B_W-1:0];
      end
      CMD_SP_BEND: begin
        b_q <= b_q + p_shr[B_W-1:0];
      end
      CMD_SP_C: begin
        p_q   <= prod[ACC_W-1:0];
        acc_q <= (ln == 2'd0) ? '0 : acc_q + p_q;
      end
      CMD_SP_R: begin
        p_q   <= prod[ACC_W-1:0];
        acc_q <= acc_q + p_q;
      end
      CMD_SP_CEND: begin
        acc_q <= acc_q - p_q;
      end
      CMD_SP_BB: begin
        p_q <= prod[ACC_W-1:0];
      end
      CMD_SP_DISC: begin
        acc_q <= p_q - acc_q;
      end
      CMD_SP_TIME: begin
        t_q <= -T_W'(b_q) - T_W'({1'b0, root});
      end
      default: begin
      end
    endcase
  end

  // Ray, best-hit and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        origin_q[i] <= '0;
        dir_q[i]    <= '0;
      end
      count_q      <= '0;
      best_time_q  <= '1;
      best_index_q <= '0;
      best_valid_q <= 1'b0;
      valid_q      <= 1'b0;
      res_q        <= '0;
    end else begin
      valid_q <= 1'b0;
      case (ctrl_i.cmd)
        CMD_LD_DIFF: begin
          for (int i = 0; i < 3; i++) origin_q[i] <= s_vec[i];
          count_q      <= '0;
          best_time_q  <= '1;
          best_index_q <= '0;
          best_valid_q <= 1'b0;
        end
        CMD_LD_ZERO: begin
          for (int i = 0; i < 3; i++) dir_q[i] <= '0;
        end
        CMD_DIV_STORE: begin
          dir_q[ln] <= neg_q[ln] ? -DIR_W'({1'b0, quo_q}) : DIR_W'({1'b0, quo_q});
        end
        CMD_SP_OC: begin
          count_q <= count_q + 1'b1;
        end
        CMD_SP_UPD: begin
          if (!t_q[T_W-1] && (t16 < best_time_q)) begin
            best_time_q  <= t16;
            best_index_q <= idx_q;
            best_valid_q <= 1'b1;
          end
        end
        CMD_EMIT: begin
          valid_q             <= 1'b1;
          res_q.hit           <= best_valid_q;
          res_q.nearest_index <= best_valid_q ? best_index_q : '0;
          res_q.nearest_time  <= best_valid_q ? best_time_q[30:0] : '0;
          count_q      <= '0;
          best_time_q  <= '1;
          best_index_q <= '0;
          best_valid_q <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // Status to the controller
  always_comb begin
    stat_o.op        = in_q.op;
    stat_o.last      = in_q.last;
    stat_o.m_zero    = (m_max == '0);
    stat_o.m_big     = |m_max[DIFF_W-1:NORM_SHIFT];
    stat_o.m_small   = ~m_max[NORM_SHIFT-1];
    stat_o.root_busy = root_busy;
    stat_o.div_last  = (dcnt_q == DIV_CNT_W'(DIV_STEPS - 1));
    stat_o.cnt_full  = (count_q >= CNT_W'(MAX_SPHERES));
    stat_o.dir_zero  = (dir_q[0] == '0) && (dir_q[1] == '0) && (dir_q[2] == '0);
    stat_o.disc_neg  = acc_q[ACC_W-1];
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

### sim/ray_sphere_nearest_pick_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ray_sphere_nearest_pick_tb: self-checking bench for the nearest-hit picker
// Drives a table of directed ray and sphere items, then random series of a
// ray load followed by spheres. Bursty start with random gaps. Every result
// is checked field by field against a fixed-point model or the row's result.
// ---------------------------------------------------------------------------
module ray_sphere_nearest_pick_tb;
  import rsnp_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int DRAIN_CYCLES = 2000;
  localparam int UNIT = 65536;      // one whole unit in Q16.16

  typedef struct {
    in_t  item;
    bit   typed;                    // expected result written in the row
    out_t res;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  in_t  in_i;
  logic valid_o;
  out_t res_o;

  ray_sphere_nearest_pick dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .in_i   (in_i),
    .valid_o(valid_o),
    .res_o  (res_o)
  );

  // Picker state as seen by the predictor
  longint    ray_org[3];
  longint    ray_dir[3];
  bit [31:0] best_t;
  int        best_idx;
  bit        best_ok;
  int        sph_cnt;

  out_t      pick_q[$];
  stim_row_t dir_rows[$];
  int        n_fail = 0;
  int        n_items;
  int        n_results = 0;
  int        n_hits = 0;
  int        n_cycles = 0;
  int        burst_left;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Cycle limit
  always @(posedge clk_i) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic bit [63:0] isqrt(bit [63:0] x);
    bit [63:0] res;
    bit [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x   = x - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  task automatic clear_pick();
    best_t   = 32'hFFFF_FFFF;
    best_idx = 0;
    best_ok  = 1'b0;
    sph_cnt  = 0;
  endtask

  // Ray load: origin, unit direction in Q1.30
  task automatic load_ray(in_t it);
    longint    s[3];
    longint    e[3];
    longint    d;
    bit [63:0] a[3];
    bit        neg[3];
    bit [63:0] m;
    bit [63:0] sum;
    bit [63:0] mag;
    longint    q;
    s[0] = longint'($signed(it.ray_start_x));
    s[1] = longint'($signed(it.ray_start_y));
    s[2] = longint'($signed(it.ray_start_z));
    e[0] = longint'($signed(it.ray_end_x));
    e[1] = longint'($signed(it.ray_end_y));
    e[2] = longint'($signed(it.ray_end_z));
    m = 0;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      d = e[i] - s[i];
      ray_org[i] = s[i];
      neg[i] = d < 0;
      a[i] = (d < 0) ? -d : d;
      if (a[i] > m) m = a[i];
    end
    clear_pick();
    if (m == 0) begin
      for (int i = 0; i < 3; i++) ray_dir[i] = 0;
      return;
    end
    while (m >= (64'd1 << 30)) begin
      m = m >> 1;
      for (int i = 0; i < 3; i++) a[i] = a[i] >> 1;
    end
    while (m < (64'd1 << 29)) begin
      m = m << 1;
      for (int i = 0; i < 3; i++) a[i] = a[i] << 1;
    end
    for (int i = 0; i < 3; i++) sum = sum + a[i] * a[i];
    mag = isqrt(sum);
    for (int i = 0; i < 3; i++) begin
      q = longint'((a[i] << 30) / mag);
      ray_dir[i] = neg[i] ? -q : q;
    end
  endtask

  // Sphere test: nearer root, keep the strictly smaller non-negative time
  task automatic test_sphere(in_t it);
    longint oc8[3];
    longint c[3];
    longint b8;
    longint c16;
    longint disc;
    longint t8;
    longint r;
    bit [31:0] t16;
    int idx;
    if (sph_cnt >= MAX_SPHERES) return;
    idx = sph_cnt;
    sph_cnt++;
    if (ray_dir[0] == 0 && ray_dir[1] == 0 && ray_dir[2] == 0) return;
    c[0] = longint'($signed(it.center_x));
    c[1] = longint'($signed(it.center_y));
    c[2] = longint'($signed(it.center_z));
    r = longint'(it.radius);
    b8 = 0;
    c16 = 0;
    for (int i = 0; i < 3; i++) oc8[i] = (ray_org[i] - c[i] * UNIT) >>> 8;
    for (int i = 0; i < 3; i++) begin
      b8  = b8 + ((oc8[i] * ray_dir[i]) >>> 30);
      c16 = c16 + oc8[i] * oc8[i];
    end
    c16 = c16 - r * r;
    disc = b8 * b8 - c16;
    if (disc < 0) return;
    t8 = -b8 - longint'(isqrt(disc));
    if (t8 < 0) return;
    t16 = (t8 * 256 > longint'(TIME_MAX)) ? {1'b0, TIME_MAX} : 32'(t8 * 256);
    if (t16 < best_t) begin
      best_t   = t16;
      best_idx = idx;
      best_ok  = 1'b1;
    end
  endtask

  // Advance the model by one accepted item; returns 1 with a pick result
  task automatic predict_pick(in_t it, output bit emits, output out_t pick);
    emits = 1'b0;
    pick  = '0;
    if (it.op == OP_LOAD) begin
      load_ray(it);
      return;
    end
    test_sphere(it);
    if (!it.last) return;
    emits = 1'b1;
    if (best_ok) begin
      pick.hit           = 1'b1;
      pick.nearest_index = best_idx[INDEX_W-1:0];
      pick.nearest_time  = best_t[30:0];
    end
    clear_pick();
  endtask

  // Present one item, honoring the burst/gap pattern, and wait for transfer
  task automatic send_item(in_t it, bit typed, out_t typed_res);
    bit   emits;
    out_t pick;
    int   gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      burst_left = $urandom_range(1, 15);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    start <= 1'b1;
    in_i  <= it;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    predict_pick(it, emits, pick);
    n_items++;
    if (emits) pick_q.push_back(typed ? typed_res : pick);
  endtask

  // Result check
  always @(posedge clk_i) begin
    if (rst_ni && valid_o) begin
      if (pick_q.size() == 0) begin
        $error("unexpected result hit=%0d index=%0d time=%0h",
               res_o.hit, res_o.nearest_index, res_o.nearest_time);
        n_fail++;
      end else begin
        if (res_o.hit !== pick_q[0].hit) begin
          $error("hit: expected %0d, actual %0d", pick_q[0].hit, res_o.hit);
          n_fail++;
        end
        if (res_o.nearest_index !== pick_q[0].nearest_index) begin
          $error("nearest_index: expected %0d, actual %0d",
                 pick_q[0].nearest_index, res_o.nearest_index);
          n_fail++;
        end
        if (res_o.nearest_time !== pick_q[0].nearest_time) begin
          $error("nearest_time: expected %0h, actual %0h",
                 pick_q[0].nearest_time, res_o.nearest_time);
          n_fail++;
        end
        if (pick_q[0].hit) n_hits++;
        void'(pick_q.pop_front());
        n_results++;
      end
    end
  end

  function automatic in_t mk_load(int sx, int sy, int sz, int ex, int ey, int ez,
                                  bit last);
    in_t it;
    it = '0;
    it.op = OP_LOAD;
    it.ray_start_x = sx;
    it.ray_start_y = sy;
    it.ray_start_z = sz;
    it.ray_end_x = ex;
    it.ray_end_y = ey;
    it.ray_end_z = ez;
    it.last = last;
    return it;
  endfunction

  function automatic in_t mk_sphere(int cx, int cy, int cz, int rad, bit last);
    in_t it;
    it = '0;
    it.op = OP_SPHERE;
    it.center_x = 16'(cx);
    it.center_y = 16'(cy);
    it.center_z = 16'(cz);
    it.radius = 16'(rad);
    it.last = last;
    return it;
  endfunction

  function automatic void add_row(in_t it, bit typed = 1'b0, out_t res = '0);
    stim_row_t row;
    row.item = it;
    row.typed = typed;
    row.res = res;
    dir_rows.push_back(row);
  endfunction

  function automatic int spread(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  // Random ray: mostly near the scene, sometimes raw 32-bit points
  function automatic in_t rand_load();
    in_t it;
    it = in_t'({2'b00, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                $urandom, $urandom});
    it.op = OP_LOAD;
    if ($urandom_range(0, 7) != 0) begin
      it.ray_start_x = spread(50 * UNIT);
      it.ray_start_y = spread(50 * UNIT);
      it.ray_start_z = spread(50 * UNIT);
      it.ray_end_x = spread(100 * UNIT);
      it.ray_end_y = spread(100 * UNIT);
      it.ray_end_z = spread(100 * UNIT);
    end
    if ($urandom_range(0, 19) == 0) begin
      it.ray_end_x = it.ray_start_x;
      it.ray_end_y = it.ray_start_y;
      it.ray_end_z = it.ray_start_z;
    end
    return it;
  endfunction

  function automatic in_t rand_sphere(bit last);
    in_t it;
    it = in_t'({2'b00, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                $urandom, $urandom});
    it.op = OP_SPHERE;
    if ($urandom_range(0, 7) != 0) begin
      it.center_x = 16'(spread(60));
      it.center_y = 16'(spread(60));
      it.center_z = 16'(spread(60));
      it.radius = 16'($urandom_range(0, 30 * 256));
    end
    it.last = last;
    return it;
  endfunction

  // Stimulus
  initial begin
    out_t miss;
    int   n_sph;
    bit   long_done;
    start  = 1'b0;
    in_i   = '0;
    rst_ni = 1'b0;
    n_items = 0;
    burst_left = 0;
    long_done = 1'b0;
    miss = '0;
    for (int i = 0; i < 3; i++) begin
      ray_org[i] = 0;
      ray_dir[i] = 0;
    end
    clear_pick();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table
    add_row(mk_sphere(0, 0, 5, 256, 1'b1), 1'b1, miss);           // no ray yet
    add_row(mk_load(0, 0, 0, 0, 0, 10 * UNIT, 1'b1));              // last ignored
    add_row(mk_sphere(0, 0, 5, 256, 1'b1));
    add_row(mk_sphere(0, 0, -5, 256, 1'b0));                       // behind
    add_row(mk_sphere(0, 0, 20, 512, 1'b0));
    add_row(mk_sphere(0, 0, 8, 256, 1'b1));                        // nearer later
    add_row(mk_sphere(0, 0, 9, 512, 1'b0));                        // tie
    add_row(mk_sphere(0, 0, 9, 512, 1'b1));
    add_row(mk_sphere(0, 0, 0, 16'hFFFF, 1'b1));                   // origin inside
    add_row(mk_sphere(30, 30, 5, 0, 1'b1), 1'b1, miss);            // off axis
    add_row(mk_load(-32767 * UNIT, 0, 0, 32767 * UNIT, 0, 0, 1'b0));
    add_row(mk_sphere(32767, 0, 0, 256, 1'b1));                    // far, saturates
    add_row(mk_load(5 * UNIT, 5 * UNIT, 5 * UNIT, 5 * UNIT, 5 * UNIT, 5 * UNIT,
                    1'b0));                                        // zero length
    add_row(mk_sphere(5, 5, 5, 16'hFFFF, 1'b1), 1'b1, miss);
    add_row(mk_load(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                    32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0));
    add_row(mk_sphere(-32768, -32768, -32768, 16'hFFFF, 1'b0));
    add_row(mk_sphere(32767, 32767, 32767, 16'hFFFF, 1'b0));
    add_row(mk_sphere(0, 0, 0, 16'hFFFF, 1'b1));
    add_row(mk_load(32'h7FFF_FFFF, 0, 32'h8000_0000, 32'h8000_0000, 1, 32'h7FFF_FFFF,
                    1'b0));
    add_row(mk_sphere(-32768, 0, 32767, 16'hFFFF, 1'b1));
    foreach (dir_rows[i]) send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].res);

    // Random series: a load, then spheres, last on the final one
    while (n_items < 500) begin
      if ($urandom_range(0, 9) == 0) begin
        // noise: any item at all
        send_item(($urandom_range(0, 1) == 0) ? rand_load()
                                              : rand_sphere(1'($urandom_range(0, 1))),
                  1'b0, miss);
      end else begin
        send_item(rand_load(), 1'b0, miss);
        n_sph = $urandom_range(1, 8);
        if (!long_done && n_items > 250) begin
          // wait out every pending result, then overflow the sphere counter
          start <= 1'b0;
          while (pick_q.size() != 0) @(posedge clk_i);
          burst_left = 0;
          n_sph = MAX_SPHERES + 40;
          long_done = 1'b1;
        end
        for (int k = 0; k < n_sph; k++) send_item(rand_sphere(k == n_sph - 1), 1'b0, miss);
      end
    end
    start <= 1'b0;

    // Drain
    while (pick_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Sent %0d ray/sphere items, checked %0d picks (%0d hits)",
             n_items, n_results, n_hits);
    $display("Covered empty ray, zero length, extremes, ties, saturation, overflow");
    if (n_fail == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
